/* rtl/c2p_pkg.sv */
// Package for the Cartesian-to-polar converter: payload structs, datapath widths,
// the per-stage pipeline struct and the CORDIC arctangent table function.
// No dependencies; every other file in rtl/ imports it.
`default_nettype none

package c2p_pkg;

  localparam int unsigned CoordW      = 16;
  localparam int unsigned SqW         = 32;
  localparam int unsigned RootW       = 16;
  localparam int unsigned RemW        = 18;
  localparam int unsigned CxW         = 51;
  localparam int unsigned ZW          = 33;
  localparam int unsigned FracBits    = 32;
  localparam int unsigned SqrtSteps   = 16;
  localparam int unsigned AngleW      = 16;
  localparam logic [63:0] PiQ60       = 64'h3243_F6A8_885A_308D;

  typedef struct packed {
    logic signed [CoordW-1:0] x_coord;
    logic signed [CoordW-1:0] y_coord;
  } c2p_in_t;

  typedef struct packed {
    logic [CoordW-1:0] radius;
    logic [AngleW-1:0] angle_code;
    logic              is_origin;
  } c2p_out_t;

  typedef struct packed {
    logic signed [CxW-1:0] cx;
    logic signed [CxW-1:0] cy;
    logic signed [ZW-1:0]  z;
    logic [SqW-1:0]        sq;
    logic [RootW-1:0]      root;
    logic [RemW-1:0]       rem;
    logic                  x_neg;
    logic                  origin;
  } c2p_core_t;

  // atan(2^-idx) in units where 2^31 stands for pi, rounded to nearest. The
  // series is summed in 2^-60 units and divided by pi through long division.
  function automatic logic [31:0] atan_step(input int unsigned idx);
    logic signed [63:0] acc;
    logic [63:0]        num;
    logic [63:0]        den;
    logic [63:0]        quo;
    logic [63:0]        part;
    logic [63:0]        r;
    logic [63:0]        q;
    logic [63:0]        pi_q60;
    int unsigned        e;
    pi_q60 = PiQ60;
    acc    = '0;
    if (idx == 0) begin
      return 32'h2000_0000;
    end
    for (int k = 0; k < 31; k++) begin
      e = (2 * k + 1) * idx;
      if (e < 61) begin
        num  = 64'(64'd1 << 60) >> e;
        den  = 64'(2 * k + 1);
        quo  = '0;
        part = '0;
        for (int b = 63; b >= 0; b--) begin
          part = {part[62:0], num[b]};
          if (part >= den) begin
            part   = part - den;
            quo[b] = 1'b1;
          end
        end
        if ((k & 1) != 0) begin
          acc = acc - signed'(quo);
        end else begin
          acc = acc + signed'(quo);
        end
      end
    end
    r = unsigned'(acc);
    q = '0;
    for (int b = 0; b < 32; b++) begin
      r = r << 1;
      q = q << 1;
      if (r >= pi_q60) begin
        r    = r - pi_q60;
        q[0] = 1'b1;
      end
    end
    return 32'((q + 64'd1) >> 1);
  endfunction

endpackage

`default_nettype wire

/* rtl/cartesian_to_polar_top.sv */
// Top level of the Cartesian-to-polar converter: front end, core stage chain,
// back end and the two-entry output buffer.
// Depends on c2p_pkg, c2p_prep, c2p_stage and c2p_post.
//
// Usage: points enter on the in channel (in_valid_i, in_ready_o, in_data_i)
// as signed x_coord and y_coord. Each transfer yields exactly one result on
// the out channel (out_valid_o, out_ready_i, out_data_o) with the rounded
// radius, the angle in [0, pi] coded so that 32768 is pi, and an origin flag.
// Results leave in the order the points came in.
// From an input transfer to the result appearing on out_valid_o, a point
// passes three front-end stages, one core stage per square-root digit pair or
// CORDIC micro-rotation, and the output register. Throughput is one point per
// cycle while in_ready_o is high; the core stage chain holds one point in
// each stage.
// If the receiver stalls, the pipeline keeps moving until a second result is
// parked in the skid register; only then does in_ready_o drop, and the whole
// pipeline holds without losing or repeating a point.
// Reset clears all valid bits; in_ready_o is already high during reset and
// stays high after it until a result is parked in the skid register.
`default_nettype none

module cartesian_to_polar_top #(
  parameter int unsigned ITERATIONS = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_ready_o,
  input  wire c2p_pkg::c2p_in_t  in_data_i,
  output      logic              out_valid_o,
  input  wire logic              out_ready_i,
  output      c2p_pkg::c2p_out_t out_data_o
);
  import c2p_pkg::*;

  localparam int unsigned NumCore = (ITERATIONS > SqrtSteps) ? ITERATIONS : SqrtSteps;

  logic                   en;
  logic [NumCore:0]       core_vld;
  c2p_core_t [NumCore:0]  core_dat;
  c2p_out_t               fin_dat;

  logic     out_vld_q, out_vld_d;
  logic     skid_vld_q, skid_vld_d;
  c2p_out_t out_dat_q, out_dat_d;
  c2p_out_t skid_dat_q, skid_dat_d;

  assign en = !skid_vld_q;

  c2p_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .valid_o (core_vld[0]),
    .data_o  (core_dat[0])
  );

  for (genvar g = 0; g < NumCore; g++) begin : g_core
    c2p_stage #(
      .Step       (g),
      .Iterations (ITERATIONS)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (core_vld[g]),
      .data_i  (core_dat[g]),
      .valid_o (core_vld[g+1]),
      .data_o  (core_dat[g+1])
    );
  end

  c2p_post u_post (
    .data_i (core_dat[NumCore]),
    .data_o (fin_dat)
  );

  always_comb begin
    out_vld_d  = out_vld_q;
    out_dat_d  = out_dat_q;
    skid_vld_d = skid_vld_q;
    skid_dat_d = skid_dat_q;
    if (skid_vld_q) begin
      if (out_ready_i) begin
        out_dat_d  = skid_dat_q;
        skid_vld_d = 1'b0;
      end
    end else if (out_vld_q && !out_ready_i) begin
      if (core_vld[NumCore]) begin
        skid_vld_d = 1'b1;
        skid_dat_d = fin_dat;
      end
    end else begin
      out_vld_d = core_vld[NumCore];
      out_dat_d = fin_dat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_dat_q  <= out_dat_d;
    skid_dat_q <= skid_dat_d;
  end

  assign in_ready_o  = en;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_dat_q;

  // The skid register is only ever occupied behind a full output register.
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid register holds a result while the output register is empty");

  // A result is parked only when the output register was stalled.
  a_skid_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(out_vld_q && !out_ready_i))
    else $error("skid register filled without an output stall");

  // The origin flag forces both results to zero; other points have nonzero radius.
  a_origin_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_dat_q.is_origin
                   ? (out_dat_q.radius == '0 && out_dat_q.angle_code == '0)
                   : (out_dat_q.radius != '0)))
    else $error("origin flag and radius disagree");

  // The angle never exceeds pi.
  a_angle_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_dat_q.angle_code <= 16'h8000))
    else $error("angle code above pi");

endmodule

`default_nettype wire

/* rtl/c2p_prep.sv */
// Front end of the converter: three register stages that take absolute values,
// square both coordinates and set up the square-root and CORDIC operands.
// Depends on c2p_pkg.
`default_nettype none

module c2p_prep (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire c2p_pkg::c2p_in_t  data_i,
  output      logic              valid_o,
  output      c2p_pkg::c2p_core_t data_o
);
  import c2p_pkg::*;

  logic              abs_vld_q;
  logic [CoordW-1:0] ax_q, ay_q;
  logic              xneg_q, org_q;

  logic              sqr_vld_q;
  logic [CoordW-1:0] ax2_q, ay2_q;
  logic [SqW-1:0]    sqx_q, sqy_q;
  logic              xneg2_q, org2_q;

  logic              out_vld_q;
  c2p_core_t         out_q, out_d;

  always_comb begin
    out_d        = '0;
    out_d.cx     = signed'(CxW'({ax2_q, FracBits'(0)}));
    out_d.cy     = signed'(CxW'({ay2_q, FracBits'(0)}));
    out_d.sq     = sqx_q + sqy_q;
    out_d.x_neg  = xneg2_q;
    out_d.origin = org2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      abs_vld_q <= 1'b0;
      sqr_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      abs_vld_q <= valid_i;
      sqr_vld_q <= abs_vld_q;
      out_vld_q <= sqr_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax_q    <= data_i.x_coord[CoordW-1] ? CoordW'(-data_i.x_coord) : data_i.x_coord;
      ay_q    <= data_i.y_coord[CoordW-1] ? CoordW'(-data_i.y_coord) : data_i.y_coord;
      xneg_q  <= data_i.x_coord[CoordW-1];
      org_q   <= (data_i.x_coord == '0) && (data_i.y_coord == '0);
      ax2_q   <= ax_q;
      ay2_q   <= ay_q;
      sqx_q   <= SqW'(ax_q) * SqW'(ax_q);
      sqy_q   <= SqW'(ay_q) * SqW'(ay_q);
      xneg2_q <= xneg_q;
      org2_q  <= org_q;
      out_q   <= out_d;
    end
  end

  assign valid_o = out_vld_q;
  assign data_o  = out_q;

endmodule

`default_nettype wire

/* rtl/c2p_stage.sv */
// One core pipeline stage: one digit pair of the integer square root and one
// CORDIC vectoring micro-rotation, each enabled by the stage index.
// Depends on c2p_pkg.
`default_nettype none

module c2p_stage #(
  parameter int unsigned Step       = 0,
  parameter int unsigned Iterations = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               valid_i,
  input  wire c2p_pkg::c2p_core_t data_i,
  output      logic               valid_o,
  output      c2p_pkg::c2p_core_t data_o
);
  import c2p_pkg::*;

  localparam logic [ZW-1:0] AtanStep = ZW'(atan_step(Step));
  localparam bit            DoSqrt   = (Step < SqrtSteps);
  localparam bit            DoCordic = (Step < Iterations);

  logic          vld_q;
  c2p_core_t     dat_q, dat_d;
  logic [RemW+1:0] rem_sh;
  logic [RemW+1:0] trial;
  logic signed [CxW-1:0] dx, dy;

  always_comb begin
    dat_d  = data_i;
    rem_sh = {data_i.rem, data_i.sq[SqW-1 -: 2]};
    trial  = (RemW+2)'({data_i.root, 2'b01});
    dx     = data_i.cy >>> Step;
    dy     = data_i.cx >>> Step;
    if (DoSqrt) begin
      dat_d.sq = data_i.sq << 2;
      if (rem_sh >= trial) begin
        dat_d.rem  = RemW'(rem_sh - trial);
        dat_d.root = {data_i.root[RootW-2:0], 1'b1};
      end else begin
        dat_d.rem  = RemW'(rem_sh);
        dat_d.root = {data_i.root[RootW-2:0], 1'b0};
      end
    end
    if (DoCordic) begin
      if (!data_i.cy[CxW-1]) begin
        dat_d.cx = data_i.cx + dx;
        dat_d.cy = data_i.cy - dy;
        dat_d.z  = data_i.z + signed'(AtanStep);
      end else begin
        dat_d.cx = data_i.cx - dx;
        dat_d.cy = data_i.cy + dy;
        dat_d.z  = data_i.z - signed'(AtanStep);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dat_q <= dat_d;
    end
  end

  assign valid_o = vld_q;
  assign data_o  = dat_q;

endmodule

`default_nettype wire

/* rtl/c2p_post.sv */
// Back end of the converter: rounds the square root, saturates, reflects and
// rounds the CORDIC angle, and forces zeros for the origin.
// Depends on c2p_pkg.
`default_nettype none

module c2p_post (
  input  wire c2p_pkg::c2p_core_t data_i,
  output      c2p_pkg::c2p_out_t  data_o
);
  import c2p_pkg::*;

  localparam logic signed [ZW-1:0] ZMax = ZW'(64'd1 << 30);

  logic [30:0] z_sat;
  logic [31:0] z_refl;
  logic [31:0] z_rnd;
  logic        round_up;

  always_comb begin
    if (data_i.z[ZW-1]) begin
      z_sat = '0;
    end else if (data_i.z > ZMax) begin
      z_sat = 31'(ZMax);
    end else begin
      z_sat = data_i.z[30:0];
    end
    z_refl   = data_i.x_neg ? (32'h8000_0000 - 32'(z_sat)) : 32'(z_sat);
    z_rnd    = z_refl + 32'h0000_8000;
    round_up = (RemW'(data_i.root) < data_i.rem);
    if (data_i.origin) begin
      data_o = '{radius: '0, angle_code: '0, is_origin: 1'b1};
    end else begin
      data_o.radius     = data_i.root + RootW'(round_up);
      data_o.angle_code = z_rnd[31:16];
      data_o.is_origin  = 1'b0;
    end
  end

endmodule

`default_nettype wire

/* tb/cartesian_to_polar_top_tb.sv */
// Self-checking testbench for cartesian_to_polar_top: a table of directed points, then random
// points under three pacing phases, checked against table values or an in-bench CORDIC predictor.
// Depends on c2p_pkg and the RTL of cartesian_to_polar_top.
`default_nettype none

module cartesian_to_polar_top_tb;

  localparam int unsigned Iters      = 16;
  localparam int          Steps      = (Iters < 24) ? int'(Iters) : 24;
  localparam int          Latency    = ((Iters > 16) ? int'(Iters) : 16) + 4;
  localparam int          StallLimit = 2000;
  localparam int          NumRows    = 20;
  localparam longint      QuarterTurn = 64'sd1 <<< 30;
  localparam longint      HalfTurn    = 64'sd1 <<< 31;
  localparam longint unsigned PiQ60   = 64'h3243_F6A8_885A_308D;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               known;
    c2p_pkg::c2p_out_t  res;
  } point_row_t;

  localparam point_row_t PointRows [NumRows] = '{
    '{x: 16'sd0,     y: 16'sd0,     known: 1'b1,
      res: '{radius: 16'd0, angle_code: 16'd0, is_origin: 1'b1}},
    '{x: 16'sh8000,  y: 16'sd0,     known: 1'b1,
      res: '{radius: 16'd32768, angle_code: 16'd32768, is_origin: 1'b0}},
    '{x: 16'sd32767, y: 16'sd0,     known: 1'b0, res: '0},
    '{x: 16'sh8000,  y: 16'sh8000,  known: 1'b0, res: '0},
    '{x: 16'sd32767, y: 16'sd32767, known: 1'b0, res: '0},
    '{x: 16'sh8000,  y: 16'sd32767, known: 1'b0, res: '0},
    '{x: 16'sd32767, y: 16'sh8000,  known: 1'b0, res: '0},
    '{x: 16'sd0,     y: 16'sd32767, known: 1'b0, res: '0},
    '{x: 16'sd0,     y: 16'sh8000,  known: 1'b0, res: '0},
    '{x: 16'sd1,     y: 16'sd0,     known: 1'b0, res: '0},
    '{x: -16'sd1,    y: 16'sd0,     known: 1'b0, res: '0},
    '{x: 16'sd0,     y: 16'sd1,     known: 1'b0, res: '0},
    '{x: 16'sd0,     y: -16'sd1,    known: 1'b0, res: '0},
    '{x: 16'sd1,     y: 16'sd1,     known: 1'b0, res: '0},
    '{x: -16'sd1,    y: -16'sd1,    known: 1'b0, res: '0},
    '{x: 16'sd3,     y: 16'sd4,     known: 1'b0, res: '0},
    '{x: -16'sd3,    y: -16'sd4,    known: 1'b0, res: '0},
    '{x: 16'sd1,     y: 16'sh8000,  known: 1'b0, res: '0},
    '{x: 16'sd100,   y: -16'sd100,  known: 1'b0, res: '0},
    '{x: -16'sd32767, y: 16'sd1,    known: 1'b0, res: '0}
  };

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  c2p_pkg::c2p_in_t  in_data_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  c2p_pkg::c2p_out_t out_data_o;

  c2p_pkg::c2p_out_t pending_polar [$];
  longint            arctan_lut [24];
  int                send_idle_pct = 10;
  int                recv_stall_pct = 30;
  int                err_count = 0;
  int                n_points = 0;
  int                n_origin = 0;
  int                n_neg_x = 0;

  cartesian_to_polar_top #(
    .ITERATIONS(Iters)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Arctangent of 2^-idx in units where 2^31 is pi: a 2^-60 series, then long division by pi.
  function automatic longint arctan_unit(input int idx);
    longint          sum;
    longint          term;
    longint unsigned rem;
    longint unsigned quo;
    int              k;
    int              b;
    if (idx == 0) begin
      return 64'sd1 <<< 29;
    end
    sum = 0;
    for (k = 0; (2 * k + 1) * idx < 61; k++) begin
      term = longint'((64'd1 << 60) >> ((2 * k + 1) * idx)) / longint'(2 * k + 1);
      sum = (k % 2 == 1) ? sum - term : sum + term;
    end
    rem = longint'(unsigned'(sum));
    quo = 0;
    for (b = 0; b < 32; b++) begin
      rem = rem << 1;
      quo = quo << 1;
      if (rem >= PiQ60) begin
        rem = rem - PiQ60;
        quo = quo | 64'd1;
      end
    end
    return longint'((quo + 64'd1) >> 1);
  endfunction

  function automatic c2p_pkg::c2p_out_t to_polar(input c2p_pkg::c2p_in_t pt);
    c2p_pkg::c2p_out_t res;
    longint            sx;
    longint            sy;
    longint            ax;
    longint            ay;
    longint            cx;
    longint            cy;
    longint            dx;
    longint            dy;
    longint            z;
    longint unsigned   sum_sq;
    longint unsigned   root;
    longint unsigned   trial;
    int                i;
    int                b;
    res = '0;
    sx = longint'(pt.x_coord);
    sy = longint'(pt.y_coord);
    if (sx == 0 && sy == 0) begin
      res.is_origin = 1'b1;
      return res;
    end
    ax = (sx < 0) ? -sx : sx;
    ay = (sy < 0) ? -sy : sy;

    sum_sq = longint'(unsigned'(ax * ax + ay * ay));
    root = 0;
    for (b = 16; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= sum_sq) begin
        root = trial;
      end
    end
    if (sum_sq - root * root > root) begin
      root = root + 64'd1;
    end

    cx = ax <<< 32;
    cy = ay <<< 32;
    z = 0;
    for (i = 0; i < Steps; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx = cx + dx;
        cy = cy - dy;
        z = z + arctan_lut[i];
      end else begin
        cx = cx - dx;
        cy = cy + dy;
        z = z - arctan_lut[i];
      end
    end
    if (z < 0) begin
      z = 0;
    end
    if (z > QuarterTurn) begin
      z = QuarterTurn;
    end
    if (sx < 0) begin
      z = HalfTurn - z;
    end
    res.radius = root[15:0];
    res.angle_code = 16'((z + 64'sd32768) >>> 16);
    return res;
  endfunction

  function automatic c2p_pkg::c2p_in_t random_point();
    c2p_pkg::c2p_in_t pt;
    logic signed [15:0] ends [6];
    logic signed [15:0] mag;
    ends = '{16'sh8000, -16'sd32767, -16'sd1, 16'sd0, 16'sd1, 16'sd32767};
    pt.x_coord = 16'($urandom);
    pt.y_coord = 16'($urandom);
    case ($urandom_range(9))
      0: begin
        pt.x_coord = 16'(int'($urandom_range(16)) - 8);
        pt.y_coord = 16'(int'($urandom_range(16)) - 8);
      end
      1: begin
        if ($urandom_range(1) == 0) begin
          pt.x_coord = 16'sd0;
        end else begin
          pt.y_coord = 16'sd0;
        end
      end
      2: begin
        mag = 16'($urandom_range(32767));
        pt.x_coord = ($urandom_range(1) == 0) ? mag : -mag;
        pt.y_coord = ($urandom_range(1) == 0) ? mag : -mag;
      end
      3: begin
        pt.x_coord = ends[$urandom_range(5)];
        pt.y_coord = ends[$urandom_range(5)];
      end
      default: begin
      end
    endcase
    return pt;
  endfunction

  task automatic report(input string field, input int got, input int want);
    err_count++;
    if (err_count <= 30) begin
      $display("mismatch on %s: got %0d, expected %0d", field, got, want);
    end
  endtask

  task automatic send_point(input c2p_pkg::c2p_in_t pt, input logic known,
                            input c2p_pkg::c2p_out_t res);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= pt;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    pending_polar.push_back(known ? res : to_polar(pt));
    n_points++;
    if (pt.x_coord == 16'sd0 && pt.y_coord == 16'sd0) begin
      n_origin++;
    end
    if (pt.x_coord < 0) begin
      n_neg_x++;
    end
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_polar.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    c2p_pkg::c2p_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_polar.size() == 0) begin
        report("unexpected transfer", 1, 0);
      end else begin
        want = pending_polar.pop_front();
        if (out_data_o.radius !== want.radius) begin
          report("radius", int'(out_data_o.radius), int'(want.radius));
        end
        if (out_data_o.angle_code !== want.angle_code) begin
          report("angle_code", int'(out_data_o.angle_code), int'(want.angle_code));
        end
        if (out_data_o.is_origin !== want.is_origin) begin
          report("is_origin", int'(out_data_o.is_origin), int'(want.is_origin));
        end
      end
    end
  end

  initial begin : watchdog
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $display("watchdog expired after %0d cycles without a transfer", StallLimit);
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    int phase;
    int n;
    for (int i = 0; i < 24; i++) begin
      arctan_lut[i] = arctan_unit(i);
    end
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < NumRows; r++) begin
      send_point('{x_coord: PointRows[r].x, y_coord: PointRows[r].y},
                 PointRows[r].known, PointRows[r].res);
    end
    drain_results();

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 20;
          recv_stall_pct = 85;
          n = 450;
        end
        1: begin
          send_idle_pct = 85;
          recv_stall_pct = 20;
          n = 450;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          n = 500;
        end
      endcase
      for (int k = 0; k < n; k++) begin
        send_point(random_point(), 1'b0, '0);
      end
      drain_results();
    end

    repeat (Latency + 8) @(posedge clk_i);
    $display("Converted %0d points (%0d at the origin, %0d with negative x) under three",
             n_points, n_origin, n_neg_x);
    $display("pacing phases, with the pipeline drained between phases.");
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* cartesian_to_polar_top.f */
rtl/c2p_pkg.sv
rtl/c2p_prep.sv
rtl/c2p_stage.sv
rtl/c2p_post.sv
rtl/cartesian_to_polar_top.sv
tb/cartesian_to_polar_top_tb.sv
